FILE: rtl/i2c_master_line_sequencer_core_defines.svh
// ---------------------------------------------------------------------------
// I2C line sequencer assertion macros
// Shared concurrent assertion forms for the sequencer RTL.
// ---------------------------------------------------------------------------
`ifndef I2C_MASTER_LINE_SEQUENCER_CORE_DEFINES_SVH
`define I2C_MASTER_LINE_SEQUENCER_CORE_DEFINES_SVH

// Check that a condition holds at every clock edge out of reset.
`define ILSQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger implies a consequence in the same cycle.
`define ILSQ_ASSERT_IMPLY(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ilsq_pkg.sv
// ---------------------------------------------------------------------------
// I2C line sequencer package
// Types, phase codes, command codes and register indexes.
// ---------------------------------------------------------------------------
package ilsq_pkg;

  // Command codes
  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_START = 3'd1;
  localparam logic [2:0] ACT_STOP  = 3'd2;
  localparam logic [2:0] ACT_WRITE = 3'd3;
  localparam logic [2:0] ACT_READ  = 3'd4;
  localparam logic [2:0] ACT_CHECK = 3'd5;
  localparam logic [2:0] ACT_NACK  = 3'd6;

  // Sequencer phases
  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_ST_RISE   = 4'd1;
  localparam logic [3:0] PH_ST_LOW    = 4'd2;
  localparam logic [3:0] PH_ST_HOLD   = 4'd3;
  localparam logic [3:0] PH_SP_A      = 4'd4;
  localparam logic [3:0] PH_SP_B      = 4'd5;
  localparam logic [3:0] PH_WR_RISE   = 4'd6;
  localparam logic [3:0] PH_WR_HIGH   = 4'd7;
  localparam logic [3:0] PH_WR_DATA   = 4'd8;
  localparam logic [3:0] PH_RD_RISE   = 4'd9;
  localparam logic [3:0] PH_RD_HIGH   = 4'd10;
  localparam logic [3:0] PH_CK_RISE   = 4'd11;
  localparam logic [3:0] PH_CK_SETTLE = 4'd12;
  localparam logic [3:0] PH_CK_WAIT   = 4'd13;
  localparam logic [3:0] PH_NK_RISE   = 4'd14;
  localparam logic [3:0] PH_NK_HIGH   = 4'd15;

  // Register indexes
  localparam logic [2:0] REG_BIT_HOLD      = 3'd0;
  localparam logic [2:0] REG_EDGE_HOLD     = 3'd1;
  localparam logic [2:0] REG_POLL_LIMIT    = 3'd2;
  localparam logic [2:0] REG_POLL_INTERVAL = 3'd3;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic [7:0] bit_hold;
    logic [7:0] edge_hold;
    logic [7:0] poll_limit;
    logic [7:0] poll_interval;
  } ilsq_cfg_t;

  localparam ilsq_cfg_t CFG_RESET = '{
    bit_hold:      8'd8,
    edge_hold:     8'd10,
    poll_limit:    8'd200,
    poll_interval: 8'd200
  };

  typedef struct packed {
    logic [3:0] phase;
    logic [3:0] bit_count;
    logic [7:0] shift_reg;
    logic [7:0] wait_count;
    logic [7:0] poll_count;
    logic       scl_line;
    logic       sda_line;
    logic       sda_enable;
    logic       ack_flag;
    logic [7:0] read_byte;
  } ilsq_state_t;

  localparam ilsq_state_t STATE_RESET = '{
    phase:      PH_IDLE,
    bit_count:  4'd0,
    shift_reg:  8'd0,
    wait_count: 8'd0,
    poll_count: 8'd0,
    scl_line:   1'b1,
    sda_line:   1'b1,
    sda_enable: 1'b1,
    ack_flag:   1'b0,
    read_byte:  8'd0
  };

endpackage

FILE: rtl/ilsq_cfg_regs.sv
// ---------------------------------------------------------------------------
// I2C line sequencer configuration registers
// Holds the four timing registers written over the configuration channel.
// ---------------------------------------------------------------------------
module ilsq_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic [2:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  output logic              cfg_ready,
  output ilsq_pkg::ilsq_cfg_t cfg
);
  import ilsq_pkg::*;

  ilsq_cfg_t cfg_r;
  ilsq_cfg_t cfg_nxt;

  // Write only while idle; the block does not enforce this and accepts every transfer.
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_BIT_HOLD:      cfg_nxt.bit_hold      = cfg_data;
        REG_EDGE_HOLD:     cfg_nxt.edge_hold     = cfg_data;
        REG_POLL_LIMIT:    cfg_nxt.poll_limit    = cfg_data;
        REG_POLL_INTERVAL: cfg_nxt.poll_interval = cfg_data;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: rtl/ilsq_step.sv
// ---------------------------------------------------------------------------
// I2C line sequencer step logic
// Next state of the pin sequencer for one tick.
// ---------------------------------------------------------------------------
module ilsq_step (
  input  ilsq_pkg::ilsq_state_t st,
  input  ilsq_pkg::ilsq_cfg_t   cfg,
  input  logic [2:0]            action,
  input  logic [7:0]            write_data,
  input  logic                  sda_level,
  output ilsq_pkg::ilsq_state_t st_nxt,
  output logic                  done,
  output logic                  rejected
);
  import ilsq_pkg::*;

  logic       cmd;
  logic       hold_over;
  logic       do_poll;
  logic [7:0] poll_cur;
  logic [3:0] bit_dec;

  assign cmd       = (action >= ACT_START) && (action <= ACT_NACK);
  assign hold_over = (st.wait_count <= 8'd1);
  assign bit_dec   = st.bit_count - 4'd1;
  // Poll count is loaded from the limit on the settle tick.
  assign poll_cur  = (st.phase == PH_CK_SETTLE) ? cfg.poll_limit : st.poll_count;

  always_comb begin
    st_nxt   = st;
    done     = 1'b0;
    rejected = 1'b0;
    do_poll  = 1'b0;
    if (st.phase == PH_IDLE) begin
      if (cmd) begin
        case (action)
          ACT_START: begin
            st_nxt.scl_line   = 1'b0;
            st_nxt.sda_line   = 1'b1;
            st_nxt.sda_enable = 1'b1;
            st_nxt.phase      = PH_ST_RISE;
          end
          ACT_STOP: begin
            st_nxt.sda_line   = 1'b0;
            st_nxt.sda_enable = 1'b1;
            st_nxt.wait_count = cfg.edge_hold;
            st_nxt.phase      = PH_SP_A;
          end
          ACT_WRITE: begin
            st_nxt.sda_enable = 1'b1;
            st_nxt.shift_reg  = write_data;
            st_nxt.bit_count  = BITS_PER_BYTE;
            st_nxt.sda_line   = write_data[7];
            st_nxt.phase      = PH_WR_RISE;
          end
          ACT_READ: begin
            st_nxt.sda_enable = 1'b0;
            st_nxt.shift_reg  = 8'd0;
            st_nxt.bit_count  = BITS_PER_BYTE;
            st_nxt.phase      = PH_RD_RISE;
          end
          ACT_CHECK: begin
            st_nxt.sda_enable = 1'b0;
            st_nxt.phase      = PH_CK_RISE;
          end
          default: begin
            st_nxt.sda_enable = 1'b1;
            st_nxt.sda_line   = 1'b1;
            st_nxt.phase      = PH_NK_RISE;
          end
        endcase
      end
    end else begin
      rejected = cmd;
      // Count down any running hold; a finished hold leaves the counter.
      if (!hold_over) begin
        st_nxt.wait_count = st.wait_count - 8'd1;
      end
      case (st.phase)
        PH_ST_RISE: begin
          st_nxt.scl_line = 1'b1;
          st_nxt.phase    = PH_ST_LOW;
        end
        PH_ST_LOW: begin
          st_nxt.sda_line   = 1'b0;
          st_nxt.wait_count = cfg.edge_hold;
          st_nxt.phase      = PH_ST_HOLD;
        end
        PH_ST_HOLD: begin
          if (hold_over) begin
            st_nxt.scl_line = 1'b0;
            st_nxt.phase    = PH_IDLE;
            done            = 1'b1;
          end
        end
        PH_SP_A: begin
          if (hold_over) begin
            st_nxt.scl_line   = 1'b1;
            st_nxt.wait_count = cfg.edge_hold;
            st_nxt.phase      = PH_SP_B;
          end
        end
        PH_SP_B: begin
          if (hold_over) begin
            st_nxt.sda_line = 1'b1;
            st_nxt.phase    = PH_IDLE;
            done            = 1'b1;
          end
        end
        PH_WR_RISE, PH_RD_RISE: begin
          st_nxt.scl_line   = 1'b1;
          st_nxt.wait_count = cfg.bit_hold;
          st_nxt.phase      = (st.phase == PH_WR_RISE) ? PH_WR_HIGH : PH_RD_HIGH;
        end
        PH_WR_HIGH: begin
          if (hold_over) begin
            st_nxt.scl_line  = 1'b0;
            st_nxt.shift_reg = {st.shift_reg[6:0], 1'b0};
            st_nxt.bit_count = bit_dec;
            if (bit_dec == 4'd0) begin
              st_nxt.phase = PH_IDLE;
              done         = 1'b1;
            end else begin
              st_nxt.phase = PH_WR_DATA;
            end
          end
        end
        PH_WR_DATA: begin
          st_nxt.sda_line = st.shift_reg[7];
          st_nxt.phase    = PH_WR_RISE;
        end
        PH_RD_HIGH: begin
          if (hold_over) begin
            st_nxt.shift_reg = {st.shift_reg[6:0], sda_level};
            st_nxt.scl_line  = 1'b0;
            st_nxt.bit_count = bit_dec;
            if (bit_dec == 4'd0) begin
              st_nxt.read_byte = {st.shift_reg[6:0], sda_level};
              st_nxt.phase     = PH_IDLE;
              done             = 1'b1;
            end else begin
              st_nxt.phase = PH_RD_RISE;
            end
          end
        end
        PH_CK_RISE, PH_NK_RISE: begin
          st_nxt.scl_line   = 1'b1;
          st_nxt.wait_count = cfg.edge_hold;
          st_nxt.phase      = (st.phase == PH_CK_RISE) ? PH_CK_SETTLE : PH_NK_HIGH;
        end
        PH_CK_SETTLE, PH_CK_WAIT: begin
          do_poll = hold_over;
        end
        default: begin
          if (hold_over) begin
            st_nxt.scl_line = 1'b0;
            st_nxt.phase    = PH_IDLE;
            done            = 1'b1;
          end
        end
      endcase
      // Sample SDA for acknowledge: low is ack, no polls left is timeout.
      if (do_poll) begin
        st_nxt.poll_count = poll_cur;
        if (poll_cur == 8'd0) begin
          st_nxt.scl_line = 1'b0;
          st_nxt.ack_flag = 1'b0;
          st_nxt.phase    = PH_IDLE;
          done            = 1'b1;
        end else if (!sda_level) begin
          st_nxt.scl_line = 1'b0;
          st_nxt.ack_flag = 1'b1;
          st_nxt.phase    = PH_IDLE;
          done            = 1'b1;
        end else begin
          st_nxt.poll_count = poll_cur - 8'd1;
          st_nxt.wait_count = cfg.poll_interval;
          st_nxt.phase      = PH_CK_WAIT;
        end
      end
    end
  end

endmodule

FILE: rtl/i2c_master_line_sequencer_core.sv
// ---------------------------------------------------------------------------
// I2C master line sequencer core
// Path: a tick is held in the input register, and its result in the result register.
// Throughput: one tick per cycle while out_stall is low; the step logic runs once per transfer.
// Reset: synchronous, active low; SCL and SDA high, SDA driven, idle,
// timing registers back to their defaults, both pipeline stages empty.
// ---------------------------------------------------------------------------
module i2c_master_line_sequencer_core (
  input  logic       clk,
  input  logic       rst_n,
  // tick channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_action,
  input  logic [7:0] in_write_data,
  input  logic       in_sda_level,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_scl_out,
  output logic       out_sda_out,
  output logic       out_sda_drive,
  output logic       out_busy_res,
  output logic       out_done_res,
  output logic       out_ack_ok,
  output logic [7:0] out_read_data,
  output logic       out_rejected,
  // configuration channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import ilsq_pkg::*;

`include "i2c_master_line_sequencer_core_defines.svh"

  // Input register: one tick waiting for the step logic.
  logic       s1_valid_r,  s1_valid_nxt;
  logic [2:0] s1_action_r;
  logic [7:0] s1_wdata_r;
  logic       s1_sda_r;

  // Sequencer state, advanced once per tick that moves into the result.
  ilsq_state_t st_r;
  ilsq_state_t st_nxt;

  // Result register.
  logic        out_valid_r, out_valid_nxt;
  logic        out_done_r;
  logic        out_rej_r;
  ilsq_state_t out_st_r;

  ilsq_cfg_t cfg;
  logic      step_done;
  logic      step_rej;
  logic      accept;
  logic      advance;

  // Advance when the result slot is free or is being taken this cycle.
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  // Stall only when the input register is full and cannot drain.
  assign in_stall = s1_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  assign s1_valid_nxt  = accept || (s1_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && out_stall);

  ilsq_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .cfg       (cfg)
  );

  ilsq_step u_step (
    .st         (st_r),
    .cfg        (cfg),
    .action     (s1_action_r),
    .write_data (s1_wdata_r),
    .sda_level  (s1_sda_r),
    .st_nxt     (st_nxt),
    .done       (step_done),
    .rejected   (step_rej)
  );

  // Control state: stage valids and the sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= STATE_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        st_r <= st_nxt;
      end
    end
  end

  // Payload: capture the tick, hold it until it drains.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_action_r <= in_action;
      s1_wdata_r  <= in_write_data;
      s1_sda_r    <= in_sda_level;
    end
    if (advance) begin
      out_st_r   <= st_nxt;
      out_done_r <= step_done;
      out_rej_r  <= step_rej;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_scl_out   = out_st_r.scl_line;
  assign out_sda_out   = out_st_r.sda_line;
  assign out_sda_drive = out_st_r.sda_enable;
  assign out_busy_res  = (out_st_r.phase != PH_IDLE);
  assign out_done_res  = out_done_r;
  assign out_ack_ok    = out_st_r.ack_flag;
  assign out_read_data = out_st_r.read_byte;
  assign out_rejected  = out_rej_r;

  // A finishing tick leaves the sequencer idle.
  `ILSQ_ASSERT_IMPLY(a_done_idle, out_valid_r && out_done_r, !out_busy_res, "done while busy")
  // Stall only with a held tick in the input register.
  `ILSQ_ASSERT_IMPLY(a_stall_full, in_stall, s1_valid_r, "stall with empty input register")
  // The bit counter never exceeds one byte.
  `ILSQ_ASSERT_ALWAYS(a_bit_range, st_r.bit_count <= BITS_PER_BYTE, "bit counter out of range")

endmodule
